[sv/stp_pkg.sv]
// ----------------------------------------------------------------------------
// stp_pkg
// Shared types and constants of the trace plotter: sweep modes, key codes,
// row arithmetic widths and the trace memory write request.
// ----------------------------------------------------------------------------
package stp_pkg;

    localparam int COLUMNS   = 128;
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int ROW_W     = 6;
    localparam int STEP_W    = 6;
    localparam int ACC_W     = 21;
    localparam int PROD_W    = 16;
    localparam int DIV_W     = 22;
    localparam int ROW_DENOM = 42075;

    typedef logic [COL_W-1:0]          col_t;
    typedef logic [ROW_W-1:0]          row_t;
    typedef logic [2:0]                page_t;
    typedef logic [7:0]                pat_t;
    typedef logic signed [STEP_W-1:0]  step_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic [DIV_W-1:0]          div_t;

    localparam col_t  SKIP_COLUMN = col_t'(64);
    localparam page_t AXIS_PAGE   = 3'd4;
    localparam step_t STEP_MAX    = 6'sd31;
    localparam step_t STEP_MIN    = -6'sd32;

    // 64*a above -ROW_DENOM truncates to zero, so small negatives still draw
    localparam acc_t DRAW_LO = -21'sd657;
    localparam acc_t DRAW_HI = 21'sd42075;

    localparam logic [7:0] KEY_GAIN_UP   = 8'h31;
    localparam logic [7:0] KEY_GAIN_DN   = 8'h32;
    localparam logic [7:0] KEY_OFFSET_UP = 8'h33;
    localparam logic [7:0] KEY_OFFSET_DN = 8'h34;
    localparam logic [7:0] START_CH1     = 8'h01;
    localparam logic [7:0] START_CH2     = 8'h02;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_CH1  = 2'd1,
        MODE_CH2  = 2'd2
    } mode_t;

    typedef struct packed {
        logic  en;
        logic  chan;
        col_t  addr;
        row_t  row;
    } mem_wr_t;

    typedef struct packed {
        page_t page;
        pat_t  pattern;
    } out_wr_t;

endpackage

[sv/scope_trace_plotter.sv]
// ----------------------------------------------------------------------------
// scope_trace_plotter
// Two-channel trace plotter: serial bytes step gain and offset or run a
// 128-column sweep; each sample yields display byte writes that erase the
// old row, restore a same-page other row and draw an in-range new row.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  rx      | rx_valid, rx_ready, rx_byte              | in
//  wr      | wr_valid, wr_ready, page, column,        | out
//          | pattern, last_write                      |
//
//  A byte is taken every cycle while the write register can load; a sample
//  then holds the write register until its up to three display writes are
//  issued, one per cycle while wr_ready is high; a key or start byte has none.
//  The first write of a sample follows its request through memory read,
//  gain multiply and row sum, upper quotient bits, then lower quotient bits
//  into the write register.
//  Reset clears the per-entry valid bits at once; no clearing pass.
//  A stall on wr freezes the whole pipeline and drops rx_ready.
//  Samples of a sweep touch consecutive columns, so a write-back never meets
//  a read of the same entry in flight.
// ----------------------------------------------------------------------------
module scope_trace_plotter (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,
    output logic       wr_valid,
    input  logic       wr_ready,
    output logic [2:0] page,
    output logic [6:0] column,
    output logic [7:0] pattern,
    output logic       last_write
);

    // front control
    stp_pkg::mode_t mode_reg,   mode_next;
    stp_pkg::col_t  col_reg,    col_next;
    stp_pkg::step_t gain_reg,   gain_next;
    stp_pkg::step_t offset_reg, offset_next;
    logic           rx_fire;
    logic           sample;
    logic           adv;

    // stage 1: memory data
    logic           s1_valid_reg;
    logic           s1_chan_reg;
    stp_pkg::col_t  s1_col_reg;
    logic [7:0]     s1_x_reg;
    stp_pkg::step_t s1_gain_reg;
    stp_pkg::step_t s1_offset_reg;
    stp_pkg::row_t  rd_row1;
    stp_pkg::row_t  rd_row2;
    stp_pkg::row_t  s1_own;
    stp_pkg::row_t  s1_oth;
    logic signed [6:0] s1_gp;
    stp_pkg::prod_t s1_prod;
    stp_pkg::acc_t  s1_acc;

    // stage 2: row sum, upper quotient bits
    logic           s2_valid_reg;
    logic           s2_chan_reg;
    stp_pkg::col_t  s2_col_reg;
    stp_pkg::row_t  s2_own_reg;
    stp_pkg::row_t  s2_oth_reg;
    stp_pkg::acc_t  s2_acc_reg;
    logic           s2_drawn;
    stp_pkg::div_t  s2_rem;
    logic [2:0]     s2_qhi;

    // stage 3: lower quotient bits, write list
    logic           s3_valid_reg;
    logic           s3_chan_reg;
    stp_pkg::col_t  s3_col_reg;
    stp_pkg::row_t  s3_own_reg;
    stp_pkg::row_t  s3_oth_reg;
    logic           s3_drawn_reg;
    stp_pkg::div_t  s3_rem_reg;
    logic [2:0]     s3_qhi_reg;
    stp_pkg::div_t  s3_rem;
    logic [2:0]     s3_qlo;
    stp_pkg::row_t  s3_new_row;
    logic           s3_same;
    logic [1:0]     s3_cnt;
    stp_pkg::out_wr_t s3_w0, s3_w1, s3_w2;
    stp_pkg::mem_wr_t mem_wr;

    // write register
    logic [1:0]       ob_cnt_reg;
    stp_pkg::col_t    ob_col_reg;
    stp_pkg::out_wr_t ob_slot_reg [3];
    logic             wr_fire;

    function automatic stp_pkg::out_wr_t with_axis(input stp_pkg::page_t pg,
                                                   input stp_pkg::pat_t pt);
        stp_pkg::out_wr_t w;
        w.page    = pg;
        w.pattern = (pg == stp_pkg::AXIS_PAGE) ? (pt | stp_pkg::pat_t'(1)) : pt;
        return w;
    endfunction

    function automatic stp_pkg::pat_t row_bit(input stp_pkg::row_t r);
        return stp_pkg::pat_t'(1) << r[2:0];
    endfunction

    // whole pipeline moves when the write register can take a new list
    assign adv      = (ob_cnt_reg == 2'd0) || ((ob_cnt_reg == 2'd1) && wr_ready);
    assign rx_ready = adv;
    assign rx_fire  = rx_valid && rx_ready;

    always_comb
    begin
        mode_next   = mode_reg;
        col_next    = col_reg;
        gain_next   = gain_reg;
        offset_next = offset_reg;
        sample      = 1'b0;
        if (rx_fire)
        begin
            unique case (mode_reg)
                stp_pkg::MODE_CH1, stp_pkg::MODE_CH2:
                begin
                    sample = 1'b1;
                    if (col_reg == stp_pkg::col_t'(stp_pkg::COLUMNS - 1))
                    begin
                        mode_next = stp_pkg::MODE_IDLE;
                        col_next  = '0;
                    end
                    else
                    begin
                        col_next = stp_pkg::col_t'(col_reg + 1'b1);
                    end
                end
                default:
                begin
                    unique case (rx_byte)
                        stp_pkg::KEY_GAIN_UP:
                        begin
                            if (gain_reg != stp_pkg::STEP_MAX)
                                gain_next = gain_reg + stp_pkg::step_t'(1);
                        end
                        stp_pkg::KEY_GAIN_DN:
                        begin
                            if (gain_reg != stp_pkg::STEP_MIN)
                                gain_next = gain_reg - stp_pkg::step_t'(1);
                        end
                        stp_pkg::KEY_OFFSET_UP:
                        begin
                            if (offset_reg != stp_pkg::STEP_MAX)
                                offset_next = offset_reg + stp_pkg::step_t'(1);
                        end
                        stp_pkg::KEY_OFFSET_DN:
                        begin
                            if (offset_reg != stp_pkg::STEP_MIN)
                                offset_next = offset_reg - stp_pkg::step_t'(1);
                        end
                        stp_pkg::START_CH1:
                        begin
                            mode_next = stp_pkg::MODE_CH1;
                            col_next  = '0;
                        end
                        stp_pkg::START_CH2:
                        begin
                            mode_next = stp_pkg::MODE_CH2;
                            col_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= stp_pkg::MODE_IDLE;
            col_reg    <= '0;
            gain_reg   <= '0;
            offset_reg <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            col_reg    <= col_next;
            gain_reg   <= gain_next;
            offset_reg <= offset_next;
        end
    end

    stp_trace_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (adv),
        .rd_addr (col_reg),
        .wr      (mem_wr),
        .rd_row1 (rd_row1),
        .rd_row2 (rd_row2)
    );

    // ---- stage 1: a = (5+g)*x*33 + 2550*o
    assign s1_own  = s1_chan_reg ? rd_row2 : rd_row1;
    assign s1_oth  = s1_chan_reg ? rd_row1 : rd_row2;
    assign s1_gp   = 7'(s1_gain_reg) + 7'sd5;
    assign s1_prod = stp_pkg::prod_t'(s1_gp) * stp_pkg::prod_t'($signed({1'b0, s1_x_reg}));
    assign s1_acc  = (stp_pkg::acc_t'(s1_prod) <<< 5) + stp_pkg::acc_t'(s1_prod)
                   + stp_pkg::acc_t'(s1_offset_reg) * 21'sd2550;

    // ---- stage 2: range check, quotient bits 5..3 of 64*a / 42075
    always_comb
    begin
        s2_drawn = (s2_acc_reg >= stp_pkg::DRAW_LO) && (s2_acc_reg < stp_pkg::DRAW_HI);
        s2_rem   = (s2_drawn && !s2_acc_reg[stp_pkg::ACC_W-1])
                 ? (stp_pkg::div_t'(s2_acc_reg[15:0]) << 6) : '0;
        s2_qhi   = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (s2_rem >= (stp_pkg::div_t'(stp_pkg::ROW_DENOM) << (5 - i)))
            begin
                s2_rem          = s2_rem - (stp_pkg::div_t'(stp_pkg::ROW_DENOM) << (5 - i));
                s2_qhi[2 - i]   = 1'b1;
            end
        end
    end

    // ---- stage 3: quotient bits 2..0, build the write list
    always_comb
    begin
        s3_rem = s3_rem_reg;
        s3_qlo = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (s3_rem >= (stp_pkg::div_t'(stp_pkg::ROW_DENOM) << (2 - i)))
            begin
                s3_rem        = s3_rem - (stp_pkg::div_t'(stp_pkg::ROW_DENOM) << (2 - i));
                s3_qlo[2 - i] = 1'b1;
            end
        end
    end

    assign s3_new_row = ~{s3_qhi_reg, s3_qlo};
    assign s3_same    = (s3_oth_reg[5:3] == s3_own_reg[5:3]);

    always_comb
    begin
        s3_w0 = with_axis(s3_own_reg[5:3], '0);
        s3_w1 = with_axis(s3_oth_reg[5:3], row_bit(s3_oth_reg));
        if (s3_new_row[5:3] != s3_oth_reg[5:3])
            s3_w2 = with_axis(s3_new_row[5:3], row_bit(s3_new_row));
        else
            s3_w2 = with_axis(s3_oth_reg[5:3], row_bit(s3_oth_reg) | row_bit(s3_new_row));
        // column 64 gets no display writes
        if (s3_col_reg == stp_pkg::SKIP_COLUMN)
            s3_cnt = 2'd0;
        else
            s3_cnt = 2'd1 + 2'(s3_same) + 2'(s3_drawn_reg);
    end

    assign mem_wr.en   = adv && s3_valid_reg && s3_drawn_reg;
    assign mem_wr.chan = s3_chan_reg;
    assign mem_wr.addr = s3_col_reg;
    assign mem_wr.row  = s3_new_row;

    // ---- pipeline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= sample;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_chan_reg   <= (mode_reg == stp_pkg::MODE_CH2);
            s1_col_reg    <= col_reg;
            s1_x_reg      <= rx_byte;
            s1_gain_reg   <= gain_reg;
            s1_offset_reg <= offset_reg;

            s2_chan_reg   <= s1_chan_reg;
            s2_col_reg    <= s1_col_reg;
            s2_own_reg    <= s1_own;
            s2_oth_reg    <= s1_oth;
            s2_acc_reg    <= s1_acc;

            s3_chan_reg   <= s2_chan_reg;
            s3_col_reg    <= s2_col_reg;
            s3_own_reg    <= s2_own_reg;
            s3_oth_reg    <= s2_oth_reg;
            s3_drawn_reg  <= s2_drawn;
            s3_rem_reg    <= s2_rem;
            s3_qhi_reg    <= s2_qhi;
        end
    end

    // ---- write register: up to three writes, issued one per cycle while wr_ready is high
    assign wr_fire = wr_valid && wr_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_cnt_reg <= 2'd0;
        end
        else if (adv)
        begin
            ob_cnt_reg <= s3_valid_reg ? s3_cnt : 2'd0;
        end
        else if (wr_fire)
        begin
            ob_cnt_reg <= ob_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ob_col_reg     <= s3_col_reg;
            ob_slot_reg[0] <= s3_w0;
            ob_slot_reg[1] <= s3_same ? s3_w1 : s3_w2;
            ob_slot_reg[2] <= s3_w2;
        end
        else if (wr_fire)
        begin
            // advance to the next pending write
            ob_slot_reg[0] <= ob_slot_reg[1];
            ob_slot_reg[1] <= ob_slot_reg[2];
        end
    end

    assign wr_valid   = (ob_cnt_reg != 2'd0);
    assign page       = ob_slot_reg[0].page;
    assign column     = ob_col_reg;
    assign pattern    = ob_slot_reg[0].pattern;
    assign last_write = (ob_cnt_reg == 2'd1);

endmodule

[sv/stp_trace_mem.sv]
// ----------------------------------------------------------------------------
// stp_trace_mem
// Stored trace rows of both channels, one synchronous memory per channel,
// read one column per cycle while rd_en is high, data registered. Per-entry
// valid bits make never-written entries read as row zero right after reset.
// ----------------------------------------------------------------------------
module stp_trace_mem (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  stp_pkg::col_t    rd_addr,
    input  stp_pkg::mem_wr_t wr,
    output stp_pkg::row_t    rd_row1,
    output stp_pkg::row_t    rd_row2
);

    stp_pkg::row_t ch1_mem [stp_pkg::COLUMNS];
    stp_pkg::row_t ch2_mem [stp_pkg::COLUMNS];

    logic [stp_pkg::COLUMNS-1:0] ch1_vld_reg;
    logic [stp_pkg::COLUMNS-1:0] ch2_vld_reg;
    stp_pkg::row_t               rd_data1_reg;
    stp_pkg::row_t               rd_data2_reg;
    logic                        rd_vld1_reg;
    logic                        rd_vld2_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en && !wr.chan)
        begin
            ch1_mem[wr.addr] <= wr.row;
        end
        if (wr.en && wr.chan)
        begin
            ch2_mem[wr.addr] <= wr.row;
        end
        if (rd_en)
        begin
            rd_data1_reg <= ch1_mem[rd_addr];
            rd_data2_reg <= ch2_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch1_vld_reg <= '0;
            ch2_vld_reg <= '0;
            rd_vld1_reg <= 1'b0;
            rd_vld2_reg <= 1'b0;
        end
        else
        begin
            if (wr.en && !wr.chan)
            begin
                ch1_vld_reg[wr.addr] <= 1'b1;
            end
            if (wr.en && wr.chan)
            begin
                ch2_vld_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld1_reg <= ch1_vld_reg[rd_addr];
                rd_vld2_reg <= ch2_vld_reg[rd_addr];
            end
        end
    end

    assign rd_row1 = rd_vld1_reg ? rd_data1_reg : '0;
    assign rd_row2 = rd_vld2_reg ? rd_data2_reg : '0;

endmodule

[bench/stp_checker.sv]
// ----------------------------------------------------------------------------
// stp_checker
// Watches the byte request channel and the display write channel of the
// trace plotter. Each accepted byte updates a private copy of the traces,
// sweep position, gain and offset, and queues the display writes it implies.
// Each accepted write is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module stp_checker
    import stp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    input  logic       rx_ready,
    input  logic [7:0] rx_byte,
    input  logic       wr_valid,
    input  logic       wr_ready,
    input  logic [2:0] page,
    input  logic [6:0] column,
    input  logic [7:0] pattern,
    input  logic       last_write,
    output int         errors,
    output int         pending,
    output int         writes_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        page_t pg;
        col_t  col;
        pat_t  pat;
        logic  last;
    } disp_wr_t;

    row_t     trace_rows [2*COLUMNS];
    mode_t    sweep_mode;
    int       sweep_col;
    int       gain_step;
    int       offset_step;
    disp_wr_t sample_writes [3];
    int       sample_cnt;
    disp_wr_t pending_writes [$];

    initial
    begin
        foreach (trace_rows[i])
            trace_rows[i] = '0;
        sweep_mode     = MODE_IDLE;
        sweep_col      = 0;
        gain_step      = 0;
        offset_step    = 0;
        sample_cnt     = 0;
        errors         = 0;
        pending        = 0;
        writes_checked = 0;
    end

    function automatic int clamp_step(input int v);
        if (v > int'(STEP_MAX))
            return int'(STEP_MAX);
        if (v < int'(STEP_MIN))
            return int'(STEP_MIN);
        return v;
    endfunction

    function automatic void add_write(input page_t pg, input col_t col, input pat_t pat);
        // axis line lives in bit 0 of its page
        if (pg == AXIS_PAGE)
            pat = pat | 8'h01;
        sample_writes[sample_cnt] = '{pg, col, pat, 1'b0};
        sample_cnt++;
    endfunction

    task automatic predict_display_writes(input logic [7:0] b);
        int       own;
        int       oth;
        int       num;
        int       q;
        row_t     own_row;
        row_t     oth_row;
        row_t     new_row;
        col_t     col;
        logic     writes;
        disp_wr_t w;
        begin
            sample_cnt = 0;
            if (sweep_mode != MODE_CH1 && sweep_mode != MODE_CH2)
            begin
                case (b)
                    KEY_GAIN_UP:   gain_step   = clamp_step(gain_step + 1);
                    KEY_GAIN_DN:   gain_step   = clamp_step(gain_step - 1);
                    KEY_OFFSET_UP: offset_step = clamp_step(offset_step + 1);
                    KEY_OFFSET_DN: offset_step = clamp_step(offset_step - 1);
                    START_CH1:
                    begin
                        sweep_mode = MODE_CH1;
                        sweep_col  = 0;
                    end
                    START_CH2:
                    begin
                        sweep_mode = MODE_CH2;
                        sweep_col  = 0;
                    end
                    default: ;
                endcase
            end
            else
            begin
                col     = col_t'(sweep_col);
                own     = (sweep_mode == MODE_CH1) ? sweep_col : COLUMNS + sweep_col;
                oth     = (sweep_mode == MODE_CH1) ? COLUMNS + sweep_col : sweep_col;
                own_row = trace_rows[own];
                oth_row = trace_rows[oth];
                writes  = (col != SKIP_COLUMN);

                // erase the old row, then restore the other trace if it shares the page
                if (writes)
                begin
                    add_write(own_row[5:3], col, 8'h00);
                    if (oth_row[5:3] == own_row[5:3])
                        add_write(oth_row[5:3], col, pat_t'(1) << oth_row[2:0]);
                end

                num = 64 * ((5 + gain_step) * int'(b) * 33 + 2550 * offset_step);
                q   = num / ROW_DENOM;
                if (q >= 0 && q <= 63)
                begin
                    new_row         = row_t'(63 - q);
                    trace_rows[own] = new_row;
                    if (writes)
                    begin
                        if (new_row[5:3] != oth_row[5:3])
                            add_write(new_row[5:3], col, pat_t'(1) << new_row[2:0]);
                        else
                            add_write(oth_row[5:3], col,
                                      (pat_t'(1) << oth_row[2:0]) | (pat_t'(1) << new_row[2:0]));
                    end
                end

                if (sweep_col == COLUMNS - 1)
                begin
                    sweep_mode = MODE_IDLE;
                    sweep_col  = 0;
                end
                else
                    sweep_col++;
            end

            for (int i = 0; i < sample_cnt; i++)
            begin
                w      = sample_writes[i];
                w.last = (i == sample_cnt - 1);
                pending_writes.push_back(w);
            end
        end
    endtask

    function automatic void check_field(input string name, input int expv, input int actv);
        if (expv != actv)
        begin
            $error("display write field %s: expected %0d, got %0d", name, expv, actv);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : watch_bus
        disp_wr_t want;
        if (rst_n)
        begin
            if (wr_valid && wr_ready)
            begin
                if (pending_writes.size() == 0)
                begin
                    $error("display write page %0d column %0d pattern %02h with none expected",
                           page, column, pattern);
                    errors++;
                end
                else
                begin
                    want = pending_writes.pop_front();
                    check_field("page", want.pg, page);
                    check_field("column", want.col, column);
                    check_field("pattern", want.pat, pattern);
                    check_field("last_write", want.last, last_write);
                    writes_checked++;
                end
            end
            if (rx_valid && rx_ready)
                predict_display_writes(rx_byte);
            pending = pending_writes.size();
        end
    end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives serial bytes into the trace plotter and takes its display writes:
// idle junk, key steps in both directions, one full sweep with corner and
// random samples, and the start of a sweep on the other channel, with
// random stalls on both sides before the tail of the first sweep.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import stp_pkg::*;

    localparam int WATCHDOG_LIMIT = 400;
    localparam int SETTLE_CYCLES  = 20;
    localparam int TAIL_SAMPLES   = 20;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       rx_valid = 1'b0;
    logic [7:0] rx_byte  = 8'h00;
    logic       wr_ready = 1'b0;
    logic       rx_ready;
    logic       wr_valid;
    logic [2:0] page;
    logic [6:0] column;
    logic [7:0] pattern;
    logic       last_write;

    int errors;
    int pending;
    int writes_checked;
    int gap_pct      = 0;
    int stall_pct    = 0;
    int stall_left   = 0;
    int quiet_cycles = 0;
    int bytes_sent   = 0;
    int sweeps_run   = 0;

    logic [7:0] corner_samples [12] = '{
        8'h00, 8'hFF, KEY_GAIN_UP, KEY_GAIN_DN, KEY_OFFSET_UP, KEY_OFFSET_DN,
        START_CH1, START_CH2, 8'h80, 8'h7F, 8'h55, 8'hAA
    };

    scope_trace_plotter DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_ready   (rx_ready),
        .rx_byte    (rx_byte),
        .wr_valid   (wr_valid),
        .wr_ready   (wr_ready),
        .page       (page),
        .column     (column),
        .pattern    (pattern),
        .last_write (last_write)
    );

    stp_checker plot_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx_valid       (rx_valid),
        .rx_ready       (rx_ready),
        .rx_byte        (rx_byte),
        .wr_valid       (wr_valid),
        .wr_ready       (wr_ready),
        .page           (page),
        .column         (column),
        .pattern        (pattern),
        .last_write     (last_write),
        .errors         (errors),
        .pending        (pending),
        .writes_checked (writes_checked)
    );

    always #5 clk = ~clk;

    // display side: drop ready in random bursts
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            wr_ready   <= 1'b0;
        end
        else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        begin
            stall_left <= $urandom_range(0, 8);
            wr_ready   <= 1'b0;
        end
        else
            wr_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (rx_valid && rx_ready) || (wr_valid && wr_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        begin
            @(negedge clk);
            if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
            begin
                gap = $urandom_range(1, 9);
                rx_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rx_valid <= 1'b1;
            rx_byte  <= b;
            do
                @(posedge clk);
            while (!rx_ready);
            bytes_sent++;
        end
    endtask

    task automatic pause_until_drained();
        @(negedge clk);
        rx_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        // a column 64 sample may still be in flight with nothing queued
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [7:0] pick_sample();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        // key and start values are plain samples mid-sweep
        if (r < 4)
            return KEY_GAIN_UP + 8'($urandom_range(0, 3));
        if (r == 4)
            return $urandom_range(0, 1) ? START_CH1 : START_CH2;
        return 8'($urandom_range(0, 255));
    endfunction

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        gap_pct   = 25;
        stall_pct = 25;
        // an idle byte that does nothing, then each key, ending one gain step up
        // and one offset step down so both clipped and drawn samples occur
        send_byte(8'h35);
        send_byte(KEY_GAIN_UP);
        send_byte(KEY_GAIN_UP);
        send_byte(KEY_GAIN_DN);
        send_byte(KEY_OFFSET_UP);
        send_byte(KEY_OFFSET_DN);
        send_byte(KEY_OFFSET_DN);
        send_byte(START_CH1);
        sweeps_run++;
        foreach (corner_samples[i])
            send_byte(corner_samples[i]);
        pause_until_drained();

        gap_pct   = 50;
        stall_pct = 50;
        repeat (COLUMNS - $size(corner_samples) - TAIL_SAMPLES) send_byte(pick_sample());

        // finish the sweep and start the other channel with no idling at all
        gap_pct   = 0;
        stall_pct = 0;
        repeat (TAIL_SAMPLES) send_byte(pick_sample());
        send_byte(START_CH2);
        sweeps_run++;
        repeat (4) send_byte(pick_sample());

        @(negedge clk);
        rx_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("run: %0d bytes, %0d sweeps started, keys stepped both ways, column 64 crossed",
                 bytes_sent, sweeps_run);
        $display("run: %0d display writes compared, %0d mismatches", writes_checked, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
